### hdl/png_stored_deflate_encoder_top_macros.svh
// Assertion macros shared by the encoder modules.
// Every module that uses them has ports named clk and rst_n.
`ifndef PNG_STORED_DEFLATE_ENCODER_TOP_MACROS_SVH
`define PNG_STORED_DEFLATE_ENCODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PNGSD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pngsd invariant violated");
`define PNGSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pngsd sequence violated");
`else
`define PNGSD_ASSERT_ALWAYS(label, cond)
`define PNGSD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/pngsd_pkg.sv
`default_nettype none

package pngsd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HAS_ALPHA    = 2'd2;

  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [63:0] PNG_SIGNATURE = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TYPE_IHDR     = 32'h49484452;
  localparam logic [31:0] TYPE_IDAT     = 32'h49444154;
  localparam logic [31:0] TYPE_IEND     = 32'h49454E44;
  localparam logic [31:0] IHDR_LENGTH   = 32'd13;
  localparam logic [15:0] ZLIB_HEADER   = 16'h7801;
  localparam logic [7:0]  BIT_DEPTH     = 8'd8;
  localparam logic [7:0]  COLOR_RGB     = 8'd2;
  localparam logic [7:0]  COLOR_RGBA    = 8'd6;

  typedef struct packed {
    logic [13:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
  } cfg_t;

  // One classified input byte as handed from the front to the back.
  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       held;
    logic [7:0] held_byte;
    logic       eor;
    logic       eoi;
    logic       bfinal;
  } cmd_t;

  function automatic logic [13:0] eff_width(cfg_t c);
    eff_width = (c.image_width == 14'd0) ? 14'd1 : c.image_width;
  endfunction

  function automatic logic [15:0] eff_height(cfg_t c);
    eff_height = (c.image_height == 16'd0) ? 16'd1 : c.image_height;
  endfunction

  function automatic logic [15:0] row_bytes(cfg_t c);
    logic [15:0] w;
    w = {2'b00, eff_width(c)};
    row_bytes = c.has_alpha ? {w[13:0], 2'b00} : (w + {w[14:0], 1'b0});
  endfunction

  function automatic logic [7:0] be_byte(logic [31:0] v, logic [1:0] k);
    case (k)
      2'd0:    be_byte = v[31:24];
      2'd1:    be_byte = v[23:16];
      2'd2:    be_byte = v[15:8];
      default: be_byte = v[7:0];
    endcase
  endfunction

  function automatic logic [31:0] crc_nib(logic [3:0] n);
    case (n)
      4'h0:    crc_nib = 32'h00000000;
      4'h1:    crc_nib = 32'h1db71064;
      4'h2:    crc_nib = 32'h3b6e20c8;
      4'h3:    crc_nib = 32'h26d930ac;
      4'h4:    crc_nib = 32'h76dc4190;
      4'h5:    crc_nib = 32'h6b6b51f4;
      4'h6:    crc_nib = 32'h4db26158;
      4'h7:    crc_nib = 32'h5005713c;
      4'h8:    crc_nib = 32'hedb88320;
      4'h9:    crc_nib = 32'hf00f9344;
      4'ha:    crc_nib = 32'hd6d6a3e8;
      4'hb:    crc_nib = 32'hcb61b38c;
      4'hc:    crc_nib = 32'h9b64c2b0;
      4'hd:    crc_nib = 32'h86d3d2d4;
      4'he:    crc_nib = 32'ha00ae278;
      default: crc_nib = 32'hbdbdf21c;
    endcase
  endfunction

  // Reflected CRC-32 over one byte, two nibbles at a time.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    c = {4'd0, c[31:4]} ^ crc_nib(c[3:0]);
    c = {4'd0, c[31:4]} ^ crc_nib(c[3:0]);
    crc_byte = c;
  endfunction

endpackage

`default_nettype wire

### hdl/png_stored_deflate_encoder_top.sv
// Uncompressed PNG stream encoder. Image bytes (R,G,B or R,G,B,A per pixel, rows top to
// bottom) go in one per transfer and the complete PNG file comes out one byte per transfer,
// with out_last marking the final byte caused by each input byte. The first byte of an
// image produces 49 output bytes (signature, IHDR, IDAT header, zlib header, first row
// header), usually one byte produces one, a row end adds 6 and the image end adds 20
// (Adler-32, IDAT CRC, IEND); after that the next byte starts a new file. The front
// classifies each byte in the cycle it arrives and can take one every cycle; a queue of QUEUE_DEPTH entries
// feeds the output sequencer, which emits one byte per cycle unless out_ready stalls it, so the sustained
// rate is one input byte per cycle inside rows and the header and trailer bursts hold off input only once
// the queue is full. The user must write width, height and alpha over cfg_we/cfg_index/cfg_data only
// while no image is in flight; the block does not enforce it. Width 0 and height 0 act as 1.

`default_nettype none

module png_stored_deflate_encoder_top #(
  parameter int QUEUE_DEPTH = pngsd_pkg::QUEUE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [pngsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pngsd_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [7:0]                          in_image_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [7:0]                               out_byte,
  output logic                                     out_last
);

  pngsd_pkg::cfg_t cfg_r;
  pngsd_pkg::cmd_t push_cmd;
  pngsd_pkg::cmd_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= 14'd1;
      cfg_r.image_height <= 16'd1;
      cfg_r.has_alpha    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        pngsd_pkg::CFG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[13:0];
        pngsd_pkg::CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[15:0];
        pngsd_pkg::CFG_HAS_ALPHA:    cfg_r.has_alpha    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pngsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_byte  (in_image_byte),
    .in_ready (in_ready),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pngsd_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  pngsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

### hdl/pngsd_front.sv
`default_nettype none

module pngsd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pngsd_pkg::cfg_t  cfg,
  input  wire logic             in_valid,
  input  wire logic [7:0]       in_byte,
  output logic                  in_ready,
  input  wire logic             q_full,
  output logic                  push,
  output pngsd_pkg::cmd_t       push_cmd
);

  logic        started_r, started_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic [15:0] row_index_r, row_index_nxt;
  logic [15:0] byte_in_row_r, byte_in_row_nxt;

  logic [15:0] eff_h;
  logic [15:0] rb;
  logic [15:0] bin_inc;
  logic [15:0] ri_inc;
  logic        row_end;
  logic        img_end;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    eff_h   = pngsd_pkg::eff_height(cfg);
    rb      = pngsd_pkg::row_bytes(cfg);
    bin_inc = byte_in_row_r + 16'd1;
    ri_inc  = row_index_r + 16'd1;
    row_end = bin_inc >= rb;
    img_end = row_end && ((ri_inc >= eff_h) || (ri_inc == 16'd0));

    push_cmd.start     = !started_r;
    push_cmd.data      = in_byte;
    push_cmd.held      = started_r && held_valid_r;
    push_cmd.held_byte = held_byte_r;
    push_cmd.eor       = started_r && row_end;
    push_cmd.eoi       = started_r && img_end;
    push_cmd.bfinal    = started_r ? (({1'b0, ri_inc} + 17'd1) >= {1'b0, eff_h})
                                   : (eff_h == 16'd1);

    started_nxt     = started_r;
    held_valid_nxt  = held_valid_r;
    held_byte_nxt   = held_byte_r;
    row_index_nxt   = row_index_r;
    byte_in_row_nxt = byte_in_row_r;

    if (push) begin
      if (!started_r) begin
        // The first byte of an image waits for the next transfer.
        started_nxt     = 1'b1;
        held_valid_nxt  = 1'b1;
        held_byte_nxt   = in_byte;
        row_index_nxt   = 16'd0;
        byte_in_row_nxt = 16'd1;
      end else begin
        held_valid_nxt  = 1'b0;
        byte_in_row_nxt = row_end ? 16'd0 : bin_inc;
        if (row_end) begin
          row_index_nxt = ri_inc;
        end
        if (img_end) begin
          started_nxt   = 1'b0;
          row_index_nxt = 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r     <= 1'b0;
      held_valid_r  <= 1'b0;
      row_index_r   <= 16'd0;
      byte_in_row_r <= 16'd0;
    end else begin
      started_r     <= started_nxt;
      held_valid_r  <= held_valid_nxt;
      row_index_r   <= row_index_nxt;
      byte_in_row_r <= byte_in_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
  end

endmodule

`default_nettype wire

### hdl/pngsd_cmd_fifo.sv
`default_nettype none

`include "png_stored_deflate_encoder_top_macros.svh"

module pngsd_cmd_fifo #(
  parameter int DEPTH = pngsd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire pngsd_pkg::cmd_t push_cmd,
  output logic             full,
  input  wire logic        pop,
  output pngsd_pkg::cmd_t  head,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pngsd_pkg::cmd_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `PNGSD_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH))
  `PNGSD_ASSERT_NEXT(a_count_grows, push && !pop, count_r == $past(count_r) + CNT_W'(1))

endmodule

`default_nettype wire

### hdl/pngsd_back.sv
`default_nettype none

`include "png_stored_deflate_encoder_top_macros.svh"

module pngsd_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire pngsd_pkg::cfg_t cfg,
  input  wire pngsd_pkg::cmd_t head,
  input  wire logic        q_empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  localparam logic [4:0] SEG_NONE      = 5'd0;
  localparam logic [4:0] SEG_SIG       = 5'd1;
  localparam logic [4:0] SEG_IHDR_LEN  = 5'd2;
  localparam logic [4:0] SEG_IHDR_TYPE = 5'd3;
  localparam logic [4:0] SEG_IHDR_DATA = 5'd4;
  localparam logic [4:0] SEG_IHDR_CRC  = 5'd5;
  localparam logic [4:0] SEG_IDAT_LEN  = 5'd6;
  localparam logic [4:0] SEG_IDAT_TYPE = 5'd7;
  localparam logic [4:0] SEG_ZLIB      = 5'd8;
  localparam logic [4:0] SEG_ROW_HDR   = 5'd9;
  localparam logic [4:0] SEG_FILTER    = 5'd10;
  localparam logic [4:0] SEG_HELD      = 5'd11;
  localparam logic [4:0] SEG_BYTE      = 5'd12;
  localparam logic [4:0] SEG_ADLER     = 5'd13;
  localparam logic [4:0] SEG_IDAT_CRC  = 5'd14;
  localparam logic [4:0] SEG_IEND_LEN  = 5'd15;
  localparam logic [4:0] SEG_IEND_TYPE = 5'd16;
  localparam logic [4:0] SEG_IEND_CRC  = 5'd17;

  localparam logic [1:0] MODE_RAW  = 2'd0;
  localparam logic [1:0] MODE_CRC  = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;

  logic [4:0]  seg_r, seg_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [15:0] adler_low_r, adler_low_nxt;
  logic [15:0] adler_high_r, adler_high_nxt;
  logic [31:0] prod_r;
  logic [31:0] idat_len_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic [4:0]  seg;
  logic [3:0]  cnt;
  logic [3:0]  seg_last;
  logic [4:0]  next_seg;
  logic [7:0]  cur_byte;
  logic [1:0]  mode;
  logic        crc_init;
  logic        cur_valid;
  logic        fire;
  logic        seg_end;
  logic        last;
  logic [31:0] crc_upd;
  logic [16:0] lo_sum;
  logic [15:0] lo_mod;
  logic [16:0] hi_sum;
  logic [15:0] hi_mod;
  logic [15:0] eff_w16;
  logic [15:0] eff_h;
  logic [15:0] row_len;
  logic [16:0] row_len6;
  logic [32:0] prod_full;

  assign eff_w16  = {2'b00, pngsd_pkg::eff_width(cfg)};
  assign eff_h    = pngsd_pkg::eff_height(cfg);
  assign row_len  = pngsd_pkg::row_bytes(cfg) + 16'd1;
  assign row_len6 = {1'b0, pngsd_pkg::row_bytes(cfg)} + 17'd6;
  assign prod_full = {17'd0, eff_h} * {16'd0, row_len6};

  // The IDAT length only depends on configuration, so it is kept ready in registers.
  always_ff @(posedge clk) begin
    prod_r     <= prod_full[31:0];
    idat_len_r <= prod_r + 32'd6;
  end

  always_comb begin
    cur_valid = (seg_r != SEG_NONE) || !q_empty;
    if (seg_r == SEG_NONE) begin
      seg = head.start ? SEG_SIG : (head.held ? SEG_HELD : SEG_BYTE);
      cnt = 4'd0;
    end else begin
      seg = seg_r;
      cnt = cnt_r;
    end

    seg_last = 4'd0;
    next_seg = SEG_NONE;
    cur_byte = 8'd0;
    mode     = MODE_RAW;
    crc_init = 1'b0;

    case (seg)
      SEG_SIG: begin
        seg_last = 4'd7;
        next_seg = SEG_IHDR_LEN;
        cur_byte = pngsd_pkg::PNG_SIGNATURE[8*(7 - int'(cnt[2:0])) +: 8];
      end
      SEG_IHDR_LEN: begin
        seg_last = 4'd3;
        next_seg = SEG_IHDR_TYPE;
        cur_byte = pngsd_pkg::be_byte(pngsd_pkg::IHDR_LENGTH, cnt[1:0]);
      end
      SEG_IHDR_TYPE: begin
        seg_last = 4'd3;
        next_seg = SEG_IHDR_DATA;
        cur_byte = pngsd_pkg::be_byte(pngsd_pkg::TYPE_IHDR, cnt[1:0]);
        mode     = MODE_CRC;
        crc_init = (cnt == 4'd0);
      end
      SEG_IHDR_DATA: begin
        seg_last = 4'd12;
        next_seg = SEG_IHDR_CRC;
        mode     = MODE_CRC;
        if (cnt < 4'd4) begin
          cur_byte = pngsd_pkg::be_byte({16'd0, eff_w16}, cnt[1:0]);
        end else if (cnt < 4'd8) begin
          cur_byte = pngsd_pkg::be_byte({16'd0, eff_h}, cnt[1:0]);
        end else if (cnt == 4'd8) begin
          cur_byte = pngsd_pkg::BIT_DEPTH;
        end else if (cnt == 4'd9) begin
          cur_byte = cfg.has_alpha ? pngsd_pkg::COLOR_RGBA : pngsd_pkg::COLOR_RGB;
        end else begin
          cur_byte = 8'd0;
        end
      end
      SEG_IHDR_CRC, SEG_IDAT_CRC, SEG_IEND_CRC: begin
        // The CRC stays put while its own bytes go out.
        seg_last = 4'd3;
        cur_byte = pngsd_pkg::be_byte(~crc_r, cnt[1:0]);
        if (seg == SEG_IHDR_CRC) begin
          next_seg = SEG_IDAT_LEN;
        end else if (seg == SEG_IDAT_CRC) begin
          next_seg = SEG_IEND_LEN;
        end else begin
          next_seg = SEG_NONE;
        end
      end
      SEG_IDAT_LEN: begin
        seg_last = 4'd3;
        next_seg = SEG_IDAT_TYPE;
        cur_byte = pngsd_pkg::be_byte(idat_len_r, cnt[1:0]);
      end
      SEG_IDAT_TYPE: begin
        seg_last = 4'd3;
        next_seg = SEG_ZLIB;
        cur_byte = pngsd_pkg::be_byte(pngsd_pkg::TYPE_IDAT, cnt[1:0]);
        mode     = MODE_CRC;
        crc_init = (cnt == 4'd0);
      end
      SEG_ZLIB: begin
        seg_last = 4'd1;
        next_seg = SEG_ROW_HDR;
        cur_byte = cnt[0] ? pngsd_pkg::ZLIB_HEADER[7:0] : pngsd_pkg::ZLIB_HEADER[15:8];
        mode     = MODE_CRC;
      end
      SEG_ROW_HDR: begin
        seg_last = 4'd4;
        next_seg = SEG_FILTER;
        mode     = MODE_CRC;
        case (cnt[2:0])
          3'd0:    cur_byte = {7'd0, head.bfinal};
          3'd1:    cur_byte = row_len[7:0];
          3'd2:    cur_byte = row_len[15:8];
          3'd3:    cur_byte = ~row_len[7:0];
          default: cur_byte = ~row_len[15:8];
        endcase
      end
      SEG_FILTER: begin
        next_seg = SEG_NONE;
        cur_byte = 8'd0;
        mode     = MODE_DATA;
      end
      SEG_HELD: begin
        next_seg = SEG_BYTE;
        cur_byte = head.held_byte;
        mode     = MODE_DATA;
      end
      SEG_BYTE: begin
        cur_byte = head.data;
        mode     = MODE_DATA;
        if (head.eor) begin
          next_seg = head.eoi ? SEG_ADLER : SEG_ROW_HDR;
        end else begin
          next_seg = SEG_NONE;
        end
      end
      SEG_ADLER: begin
        seg_last = 4'd3;
        next_seg = SEG_IDAT_CRC;
        cur_byte = pngsd_pkg::be_byte({adler_high_r, adler_low_r}, cnt[1:0]);
        mode     = MODE_CRC;
      end
      SEG_IEND_LEN: begin
        seg_last = 4'd3;
        next_seg = SEG_IEND_TYPE;
        cur_byte = 8'd0;
      end
      SEG_IEND_TYPE: begin
        seg_last = 4'd3;
        next_seg = SEG_IEND_CRC;
        cur_byte = pngsd_pkg::be_byte(pngsd_pkg::TYPE_IEND, cnt[1:0]);
        mode     = MODE_CRC;
        crc_init = (cnt == 4'd0);
      end
      default: begin
        seg_last = 4'd0;
        next_seg = SEG_NONE;
      end
    endcase

    seg_end = (cnt == seg_last);
    last    = seg_end && (next_seg == SEG_NONE);
    fire    = cur_valid && (!out_valid_r || out_ready);
    pop     = fire && last;

    crc_upd = pngsd_pkg::crc_byte(crc_init ? 32'hFFFFFFFF : crc_r, cur_byte);

    lo_sum = {1'b0, adler_low_r} + {9'd0, cur_byte};
    lo_mod = (lo_sum >= pngsd_pkg::ADLER_MOD) ? 16'(lo_sum - pngsd_pkg::ADLER_MOD)
                                              : lo_sum[15:0];
    hi_sum = {1'b0, adler_high_r} + {1'b0, lo_mod};
    hi_mod = (hi_sum >= pngsd_pkg::ADLER_MOD) ? 16'(hi_sum - pngsd_pkg::ADLER_MOD)
                                              : hi_sum[15:0];

    seg_nxt        = seg_r;
    cnt_nxt        = cnt_r;
    crc_nxt        = crc_r;
    adler_low_nxt  = adler_low_r;
    adler_high_nxt = adler_high_r;
    if (fire) begin
      seg_nxt = seg_end ? next_seg : seg;
      cnt_nxt = seg_end ? 4'd0 : cnt + 4'd1;
      if (mode != MODE_RAW) begin
        crc_nxt = crc_upd;
      end
      if (mode == MODE_DATA) begin
        adler_low_nxt  = lo_mod;
        adler_high_nxt = hi_mod;
      end
      // A new image restarts the zlib checksum.
      if (seg == SEG_SIG && cnt == 4'd0) begin
        adler_low_nxt  = 16'd1;
        adler_high_nxt = 16'd0;
      end
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r        <= SEG_NONE;
      cnt_r        <= 4'd0;
      crc_r        <= 32'hFFFFFFFF;
      adler_low_r  <= 16'd1;
      adler_high_r <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      seg_r        <= seg_nxt;
      cnt_r        <= cnt_nxt;
      crc_r        <= crc_nxt;
      adler_low_r  <= adler_low_nxt;
      adler_high_r <= adler_high_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= cur_byte;
      out_last_r <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  `PNGSD_ASSERT_ALWAYS(a_adler_low_reduced, {1'b0, adler_low_r} < pngsd_pkg::ADLER_MOD)
  `PNGSD_ASSERT_ALWAYS(a_adler_high_reduced, {1'b0, adler_high_r} < pngsd_pkg::ADLER_MOD)
  `PNGSD_ASSERT_NEXT(a_pop_marks_last, pop, out_valid_r && out_last_r)

endmodule

`default_nettype wire

### tb/tb_png_stored_deflate_encoder_top.sv
`timescale 1ns / 100ps

module tb_png_stored_deflate_encoder_top;

  // Index 3 decodes to no register and must leave the configuration alone.
  localparam logic [pngsd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_TARGET = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } png_byte_t;

  class png_stream_scoreboard;
    logic [13:0] width_reg;
    logic [15:0] height_reg;
    logic        alpha_reg;
    logic [31:0] crc;
    logic [15:0] adler_lo;
    logic [15:0] adler_hi;
    logic [15:0] row_idx;
    logic [15:0] row_pos;
    bit          in_image;
    bit          first_pending;
    logic [7:0]  first_data;
    png_byte_t   stream_q[$];
    int          errors;

    function new();
      width_reg  = 14'd1;
      height_reg = 16'd1;
      alpha_reg  = 1'b1;
      errors     = 0;
      end_image();
    endfunction

    function void end_image();
      crc           = '1;
      adler_lo      = 16'd1;
      adler_hi      = '0;
      row_idx       = '0;
      row_pos       = '0;
      in_image      = 1'b0;
      first_pending = 1'b0;
      first_data    = '0;
    endfunction

    function void apply_cfg(logic [pngsd_pkg::CFG_INDEX_W-1:0] idx,
                            logic [pngsd_pkg::CFG_W-1:0] value);
      case (idx)
        pngsd_pkg::CFG_IMAGE_WIDTH:  width_reg = value[13:0];
        pngsd_pkg::CFG_IMAGE_HEIGHT: height_reg = value;
        pngsd_pkg::CFG_HAS_ALPHA:    alpha_reg = value[0];
        default: ;
      endcase
    endfunction

    function int cols();
      return (width_reg == 14'd0) ? 1 : int'(width_reg);
    endfunction

    function int rows();
      return (height_reg == 16'd0) ? 1 : int'(height_reg);
    endfunction

    function int row_len();
      return cols() * (alpha_reg ? 4 : 3);
    endfunction

    function int pending();
      return stream_q.size();
    endfunction

    function void emit(logic [7:0] b);
      png_byte_t e;
      e.data = b;
      e.last = 1'b0;
      stream_q.push_back(e);
    endfunction

    function void emit_crc(logic [7:0] b);
      emit(b);
      crc ^= {24'd0, b};
      repeat (8) crc = crc[0] ? ((crc >> 1) ^ 32'hedb88320) : (crc >> 1);
    endfunction

    function void emit_data(logic [7:0] b);
      int lo;
      int hi;
      emit_crc(b);
      lo = (int'(adler_lo) + int'(b)) % int'(pngsd_pkg::ADLER_MOD);
      hi = (int'(adler_hi) + lo) % int'(pngsd_pkg::ADLER_MOD);
      adler_lo = 16'(lo);
      adler_hi = 16'(hi);
    endfunction

    function void emit_word(logic [31:0] v, bit with_crc);
      for (int k = 3; k >= 0; k--) begin
        if (with_crc) emit_crc(v[8*k +: 8]);
        else emit(v[8*k +: 8]);
      end
    endfunction

    function void chunk_start(logic [31:0] len, logic [31:0] ctype);
      emit_word(len, 1'b0);
      crc = '1;
      emit_word(ctype, 1'b1);
    endfunction

    function void chunk_close();
      emit_word(~crc, 1'b1);
    endfunction

    // Stored deflate block header for the current row, then filter byte 0.
    function void row_start();
      logic [15:0] len;
      len = 16'(row_len() + 1);
      emit_crc((int'(row_idx) + 1 >= rows()) ? 8'd1 : 8'd0);
      emit_crc(len[7:0]);
      emit_crc(len[15:8]);
      emit_crc(~len[7:0]);
      emit_crc(~len[15:8]);
      emit_data(8'd0);
    endfunction

    function void note_input(logic [7:0] b);
      logic [63:0] idat_len;
      png_byte_t   tail;
      if (!in_image) begin
        in_image = 1'b1;
        for (int k = 7; k >= 0; k--) emit(pngsd_pkg::PNG_SIGNATURE[8*k +: 8]);
        chunk_start(pngsd_pkg::IHDR_LENGTH, pngsd_pkg::TYPE_IHDR);
        emit_word(32'(cols()), 1'b1);
        emit_word(32'(rows()), 1'b1);
        emit_crc(pngsd_pkg::BIT_DEPTH);
        emit_crc(alpha_reg ? pngsd_pkg::COLOR_RGBA : pngsd_pkg::COLOR_RGB);
        emit_crc(8'd0);
        emit_crc(8'd0);
        emit_crc(8'd0);
        chunk_close();
        idat_len = 64'd6 + 64'(rows()) * 64'(row_len() + 6);
        chunk_start(idat_len[31:0], pngsd_pkg::TYPE_IDAT);
        emit_crc(pngsd_pkg::ZLIB_HEADER[15:8]);
        emit_crc(pngsd_pkg::ZLIB_HEADER[7:0]);
        row_idx = '0;
        row_start();
        // The first pixel byte goes out with the next transfer.
        first_data    = b;
        first_pending = 1'b1;
        row_pos       = 16'd1;
      end else begin
        if (first_pending) begin
          emit_data(first_data);
          first_pending = 1'b0;
        end
        emit_data(b);
        row_pos = row_pos + 16'd1;
        if (int'(row_pos) >= row_len()) begin
          row_pos = '0;
          row_idx = row_idx + 16'd1;
          if (int'(row_idx) >= rows() || row_idx == 16'd0) begin
            emit_word({adler_hi, adler_lo}, 1'b1);
            chunk_close();
            chunk_start(32'd0, pngsd_pkg::TYPE_IEND);
            chunk_close();
            end_image();
          end else begin
            row_start();
          end
        end
      end
      tail = stream_q.pop_back();
      tail.last = 1'b1;
      stream_q.push_back(tail);
    endfunction

    function void check_result(logic [7:0] data, logic last);
      png_byte_t exp_b;
      if (stream_q.size() == 0) begin
        $error("unexpected output transfer: out_byte=%02h out_last=%0b", data, last);
        errors++;
        return;
      end
      exp_b = stream_q.pop_front();
      if (data !== exp_b.data) begin
        $error("out_byte mismatch: expected %02h, actual %02h", exp_b.data, data);
        errors++;
      end
      if (last !== exp_b.last) begin
        $error("out_last mismatch: expected %0b, actual %0b", exp_b.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                              clk           = 1'b0;
  logic                              rst_n         = 1'b0;
  logic                              cfg_we        = 1'b0;
  logic [pngsd_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [pngsd_pkg::CFG_W-1:0]       cfg_data      = '0;
  logic                              in_valid      = 1'b0;
  logic                              in_ready;
  logic [7:0]                        in_image_byte = '0;
  logic                              out_valid;
  logic                              out_ready     = 1'b0;
  logic [7:0]                        out_byte;
  logic                              out_last;

  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  bit long_stall_req = 1'b0;

  png_stream_scoreboard png_sb = new();

  png_stored_deflate_encoder_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_image_byte (in_image_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last      (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) png_sb.check_result(out_byte, out_last);
      if (long_stall_req) begin
        hold_left      = 400;
        long_stall_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [pngsd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [pngsd_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    png_sb.apply_cfg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Valid stays high across back-to-back transfers; it only drops on a gap.
  task automatic push_pixel_byte(input logic [7:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_image_byte <= value;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    png_sb.note_input(value);
  endtask

  task automatic drain_stream();
    in_valid <= 1'b0;
    while (png_sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_image(input bit mid_pause, input bit hold_rx, output int n_bytes);
    logic [13:0] w;
    logic [15:0] h;
    logic [15:0] pad;
    w   = ($urandom_range(7) == 0) ? 14'd0 : 14'($urandom_range(4, 1));
    h   = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(3, 1));
    pad = 16'($urandom);
    // A held-off receiver needs enough bytes behind it to back the queue up into the input.
    if (hold_rx) begin
      w = 14'd4;
      h = 16'd3;
    end
    write_reg(pngsd_pkg::CFG_IMAGE_WIDTH, {pad[15:14], w});
    write_reg(pngsd_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(pngsd_pkg::CFG_HAS_ALPHA, {pad[15:1], 1'($urandom_range(1))});
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, 16'($urandom));
    n_bytes = png_sb.rows() * png_sb.row_len();
    if (hold_rx) long_stall_req = 1'b1;
    for (int k = 0; k < n_bytes; k++) begin
      if (mid_pause && k == n_bytes / 2) drain_stream();
      push_pixel_byte(8'($urandom_range(255)));
    end
    drain_stream();
  endtask

  initial begin : stimulus
    int n;
    int total;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: a single RGBA pixel.
    push_pixel_byte(8'h00);
    push_pixel_byte(8'hFF);
    push_pixel_byte(8'h80);
    push_pixel_byte(8'h7F);
    drain_stream();

    // Zero width and height behave as one; stray high data bits are dropped.
    write_reg(pngsd_pkg::CFG_IMAGE_WIDTH, 16'hC000);
    write_reg(pngsd_pkg::CFG_IMAGE_HEIGHT, 16'h0000);
    write_reg(pngsd_pkg::CFG_HAS_ALPHA, 16'hFFFE);
    write_reg(CFG_UNUSED, 16'hFFFF);
    push_pixel_byte(8'hFF);
    push_pixel_byte(8'h00);
    push_pixel_byte(8'h55);
    drain_stream();

    // Two rows, so one non-final and one final stored block.
    write_reg(pngsd_pkg::CFG_IMAGE_WIDTH, 16'h0001);
    write_reg(pngsd_pkg::CFG_IMAGE_HEIGHT, 16'h0002);
    write_reg(pngsd_pkg::CFG_HAS_ALPHA, 16'h0001);
    for (int k = 0; k < 8; k++) push_pixel_byte(8'h01 << k);
    drain_stream();

    // Largest header values make the IDAT length wrap and LEN reach 65533;
    // shrinking the image after its first byte ends it after three more bytes.
    write_reg(pngsd_pkg::CFG_IMAGE_WIDTH, 16'h3FFF);
    write_reg(pngsd_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF);
    write_reg(pngsd_pkg::CFG_HAS_ALPHA, 16'h0001);
    push_pixel_byte(8'hA5);
    drain_stream();
    write_reg(pngsd_pkg::CFG_IMAGE_WIDTH, 16'h0001);
    write_reg(pngsd_pkg::CFG_IMAGE_HEIGHT, 16'h0001);
    push_pixel_byte(8'h5A);
    push_pixel_byte(8'hC3);
    push_pixel_byte(8'h3C);
    drain_stream();

    tx_idle_pct = 29;
    rx_idle_pct = 80;
    total = 0;
    while (total < RANDOM_TARGET) begin
      random_image(total == 0, 1'b0, n);
      total += n;
    end

    tx_idle_pct = 80;
    rx_idle_pct = 29;
    total = 0;
    while (total < RANDOM_TARGET) begin
      random_image(1'b0, 1'b0, n);
      total += n;
    end

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    total = 0;
    while (total < RANDOM_TARGET) begin
      random_image(1'b0, total == 0, n);
      total += n;
    end

    if (png_sb.pending() != 0) begin
      $error("%0d expected output bytes never arrived", png_sb.pending());
      png_sb.errors++;
    end
    if (png_sb.errors == 0) begin
      $display("** png_stored_deflate_encoder_top: PASSED **");
    end else begin
      $display("** png_stored_deflate_encoder_top: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("** png_stored_deflate_encoder_top: FAILED **");
    $finish;
  end

endmodule
